[design/bounded_stable_priority_queue_unit_macros.svh]
// Assertion helpers for the priority queue
`ifndef BOUNDED_STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define BOUNDED_STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// expression holds at every edge out of reset
`define BSPQ_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("queue invariant violated");

// consequent holds in the cycle after the antecedent
`define BSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("queue sequencing violated");

`endif

[design/bspq_pkg.sv]
package bspq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CAP_W = 5;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [1:0] ST_INSERT  = 2'd0;
	localparam logic [1:0] ST_DROP    = 2'd1;
	localparam logic [1:0] ST_DEQUEUE = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] id;
		logic [31:0] size;
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [31:0] arrival;
	} entry_t;

	typedef struct packed {
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage

[design/bspq_cell.sv]
module bspq_cell
	import bspq_pkg::*;
(
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic [7:0] key,
	input  entry_t    new_entry,
	input  entry_t    left_entry,
	input  logic      left_ge,
	input  entry_t    right_entry,
	output entry_t    entry_q,
	output logic      ge
);

	assign ge = occupied && (entry_q.prio >= key);

	// insert: keep if ahead of key, take new at the boundary, else shift right; delete: take the right neighbor
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!ge) begin
				entry_q <= left_ge ? new_entry : left_entry;
			end
		end else if (ctl.del) begin
			entry_q <= right_entry;
		end
	end

endmodule

[design/bounded_stable_priority_queue_unit.sv]
// Bounded stable priority queue of packet descriptors.
// Input channel (in_valid/in_stall): kind 0 enqueues the descriptor fields,
// kind 1 dequeues the head. A transfer happens when in_valid is high and
// in_stall is low. Output channel (out_valid/out_stall): one result per
// input transfer, in order: status, the dequeued descriptor (zero unless a
// dequeue succeeded), occupancy and the saturating attempt/drop counters.
// Entries sit in a row of DEPTH cells, head at cell 0; every cell compares
// its priority with the new key, and the cells behind an insert (or all, on
// a dequeue) shift in the same cycle. One item is taken every cycle while
// in_stall is low; its result is in the output register the cycle after.
// While a result waits under out_stall, in_stall is high; new items enter
// as soon as the held result is taken (same cycle).
// cfg_wr_en/cfg_wr_data write capacity_limit (values above DEPTH act as
// DEPTH); write it only while the queue is idle.
// Reset empties the queue, clears counters and sets the capacity to 16.
module bounded_stable_priority_queue_unit
	import bspq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [15:0] packet_id,
	input  logic [7:0]  priority_req,
	input  logic [31:0] size_bits,
	input  logic [7:0]  source_node,
	input  logic [7:0]  dest_node,
	input  logic [31:0] arrival_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] out_id,
	output logic [7:0]  out_priority,
	output logic [31:0] out_size_bits,
	output logic [7:0]  out_source,
	output logic [7:0]  out_dest,
	output logic [31:0] out_arrival_bits,
	output logic [4:0]  occupancy,
	output logic [31:0] attempts_seen,
	output logic [31:0] drops_seen
);

`include "bounded_stable_priority_queue_unit_macros.svh"

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      attempts_q;
	logic [31:0]      drops_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	entry_t           out_entry_q;

	logic             in_xfer;
	logic             full;
	logic             empty;
	logic [CMP_W-1:0] eff_cap;
	cell_ctl_t        ctl;
	entry_t           new_entry;
	entry_t           cell_q [DEPTH];
	logic             ge     [DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	assign eff_cap = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
	assign full    = CMP_W'(count_q) >= eff_cap;
	assign empty   = (count_q == '0);

	assign ctl.ins = in_xfer && (kind == KIND_ENQ) && !full;
	assign ctl.del = in_xfer && (kind == KIND_DEQ) && !empty;

	assign new_entry = '{prio: priority_req, id: packet_id, size: size_bits,
		src: source_node, dst: dest_node, arrival: arrival_bits};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_g;
		logic   occ;

		if (i == 0) begin : g_head
			assign left_e = new_entry;
			assign left_g = 1'b1;
		end else begin : g_body
			assign left_e = cell_q[i-1];
			assign left_g = ge[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_e = cell_q[i];
		end else begin : g_inner
			assign right_e = cell_q[i+1];
		end

		assign occ = CNT_W'(i) < count_q;

		bspq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occupied   (occ),
			.key        (priority_req),
			.new_entry  (new_entry),
			.left_entry (left_e),
			.left_ge    (left_g),
			.right_entry(right_e),
			.entry_q    (cell_q[i]),
			.ge         (ge[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_W'(16);
			count_q     <= '0;
			attempts_q  <= '0;
			drops_q     <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_INSERT;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (in_xfer) begin
				out_valid_q <= 1'b1;
				if (kind == KIND_ENQ) begin
					if (attempts_q != '1) begin
						attempts_q <= attempts_q + 32'd1;
					end
					if (full) begin
						if (drops_q != '1) begin
							drops_q <= drops_q + 32'd1;
						end
						status_q <= ST_DROP;
					end else begin
						count_q  <= count_q + CNT_W'(1);
						status_q <= ST_INSERT;
					end
				end else begin
					if (empty) begin
						status_q <= ST_EMPTY;
					end else begin
						count_q  <= count_q - CNT_W'(1);
						status_q <= ST_DEQUEUE;
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_entry_q <= ctl.del ? cell_q[0] : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign out_id           = out_entry_q.id;
	assign out_priority     = out_entry_q.prio;
	assign out_size_bits    = out_entry_q.size;
	assign out_source       = out_entry_q.src;
	assign out_dest         = out_entry_q.dst;
	assign out_arrival_bits = out_entry_q.arrival;
	assign occupancy        = 5'(count_q);
	assign attempts_seen    = attempts_q;
	assign drops_seen       = drops_q;

	`BSPQ_ASSERT_ALWAYS(a_count_bound, clk, arst_n, CMP_W'(count_q) <= CMP_W'(DEPTH))
	`BSPQ_ASSERT_ALWAYS(a_drops_le_attempts, clk, arst_n, drops_q <= attempts_q)
	`BSPQ_ASSERT_NEXT(a_deq_result, clk, arst_n, ctl.del, out_valid_q && status_q == ST_DEQUEUE)
	`BSPQ_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid_q && out_stall, out_valid_q && $stable(status_q))

endmodule

[tb/tb_bounded_stable_priority_queue_unit.sv]
`timescale 1ns / 100ps

module tb_bounded_stable_priority_queue_unit;
	import bspq_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 80;
	localparam int PHASES      = 16;
	localparam int PHASE_ITEMS = 100;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] id;
		logic [7:0]  prio;
		logic [31:0] size;
		logic [7:0]  src;
		logic [7:0]  dst;
		logic [31:0] arrival;
		logic [4:0]  occ;
		logic [31:0] attempts;
		logic [31:0] drops;
	} sched_result_t;

	typedef struct packed {
		bit          cfg_on;
		logic [4:0]  cfg_val;
		logic        knd;
		logic [7:0]  prio;
		logic [15:0] id;
		logic [31:0] fill;
		bit          typed;
		logic [1:0]  st;
		logic [4:0]  occ;
		logic [31:0] att;
		logic [31:0] drp;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [4:0]  cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic        kind;
	logic [15:0] packet_id;
	logic [7:0]  priority_req;
	logic [31:0] size_bits;
	logic [7:0]  source_node;
	logic [7:0]  dest_node;
	logic [31:0] arrival_bits;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [15:0] out_id;
	logic [7:0]  out_priority;
	logic [31:0] out_size_bits;
	logic [7:0]  out_source;
	logic [7:0]  out_dest;
	logic [31:0] out_arrival_bits;
	logic [4:0]  occupancy;
	logic [31:0] attempts_seen;
	logic [31:0] drops_seen;

	entry_t        held_entries[$];
	logic [4:0]    cap_limit;
	logic [31:0]   attempt_tally;
	logic [31:0]   drop_tally;
	sched_result_t pending_results[$];
	plan_row_t     plan[$];

	bit            typed_on;
	sched_result_t typed_want;
	bit            calm;
	bit            long_hold_req;
	int            hold_left;
	int            idle_cycles;
	int            fail_count;

	bounded_stable_priority_queue_unit uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.kind             (kind),
		.packet_id        (packet_id),
		.priority_req     (priority_req),
		.size_bits        (size_bits),
		.source_node      (source_node),
		.dest_node        (dest_node),
		.arrival_bits     (arrival_bits),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.out_id           (out_id),
		.out_priority     (out_priority),
		.out_size_bits    (out_size_bits),
		.out_source       (out_source),
		.out_dest         (out_dest),
		.out_arrival_bits (out_arrival_bits),
		.occupancy        (occupancy),
		.attempts_seen    (attempts_seen),
		.drops_seen       (drops_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic sched_result_t predict_outcome(input logic knd, input entry_t e);
		sched_result_t r;
		entry_t        head;
		int            room;
		int            pos;
		r = '0;
		room = (int'(cap_limit) > DEPTH) ? DEPTH : int'(cap_limit);
		if (knd == KIND_ENQ) begin
			if (attempt_tally != '1)
				attempt_tally = attempt_tally + 1;
			if (held_entries.size() >= room) begin
				if (drop_tally != '1)
					drop_tally = drop_tally + 1;
				r.status = ST_DROP;
			end else begin
				pos = 0;
				while (pos < held_entries.size() && held_entries[pos].prio >= e.prio)
					pos++;
				held_entries.insert(pos, e);
				r.status = ST_INSERT;
			end
		end else if (held_entries.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			head = held_entries.pop_front();
			r.status  = ST_DEQUEUE;
			r.id      = head.id;
			r.prio    = head.prio;
			r.size    = head.size;
			r.src     = head.src;
			r.dst     = head.dst;
			r.arrival = head.arrival;
		end
		r.occ      = 5'(held_entries.size());
		r.attempts = attempt_tally;
		r.drops    = drop_tally;
		return r;
	endfunction

	// transfer monitor: prediction on input, checking on output
	always @(posedge clk) begin : monitor
		sched_result_t got;
		sched_result_t want;
		entry_t        e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {status, out_id, out_priority, out_size_bits, out_source, out_dest,
					out_arrival_bits, occupancy, attempts_seen, drops_seen};
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %p", got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p got %p", want, got);
					end
				end
			end
			if (in_valid && !in_stall) begin
				e.prio    = priority_req;
				e.id      = packet_id;
				e.size    = size_bits;
				e.src     = source_node;
				e.dst     = dest_node;
				e.arrival = arrival_bits;
				want = predict_outcome(kind, e);
				pending_results.push_back(typed_on ? typed_want : want);
			end
			if (cfg_wr_en)
				cap_limit = cfg_wr_data;
			idle_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
				0 : idle_cycles + 1;
		end
	end

	// result receiver
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
				out_stall = 1'b1;
			end else begin
				out_stall = !calm && ($urandom_range(99) < 12);
			end
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("[bounded_stable_priority_queue_unit] ERROR");
		$finish;
	end

	task automatic add_row(input bit cfg_on, input logic [4:0] cfg_val, input logic knd,
		input logic [7:0] prio, input logic [15:0] id, input logic [31:0] fill,
		input bit typed, input logic [1:0] st, input logic [4:0] occ,
		input logic [31:0] att, input logic [31:0] drp);
		plan_row_t r;
		r = {cfg_on, cfg_val, knd, prio, id, fill, typed, st, occ, att, drp};
		plan.push_back(r);
	endtask

	task automatic drive_item(input logic knd, input entry_t e, input bit typed,
		input sched_result_t tres);
		int gap;
		gap = (!calm && $urandom_range(99) < 12) ? $urandom_range(3, 1) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind         = knd;
		packet_id    = e.id;
		priority_req = e.prio;
		size_bits    = e.size;
		source_node  = e.src;
		dest_node    = e.dst;
		arrival_bits = e.arrival;
		typed_on     = typed;
		typed_want   = tres;
		in_valid     = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] v);
		drain_results();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		@(negedge clk);
	endtask

	initial begin
		entry_t        ent;
		sched_result_t tres;
		logic [4:0]    cap_plan[PHASES];
		int            enq_pct;
		int            sel;
		cap_plan = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd2, 5'd16, 5'd8,
			5'd15, 5'd3, 5'd16, 5'd31, 5'd5, 5'd16, 5'd12, 5'd16};
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		in_valid      = 1'b0;
		kind          = KIND_ENQ;
		packet_id     = '0;
		priority_req  = '0;
		size_bits     = '0;
		source_node   = '0;
		dest_node     = '0;
		arrival_bits  = '0;
		typed_on      = 1'b0;
		typed_want    = '0;
		calm          = 1'b0;
		long_hold_req = 1'b0;
		hold_left     = 0;
		idle_cycles   = 0;
		fail_count    = 0;
		cap_limit     = 5'd16;
		attempt_tally = '0;
		drop_tally    = '0;

		add_row(0, 0, KIND_DEQ, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0);
		add_row(0, 0, KIND_ENQ, 8'h00, 16'hFFFF, 32'hFFFF_FFFF, 1, ST_INSERT, 1, 1, 0);
		add_row(0, 0, KIND_ENQ, 8'hFF, 16'h0000, 32'h0000_0000, 1, ST_INSERT, 2, 2, 0);
		add_row(0, 0, KIND_ENQ, 8'd128, 16'd1, 32'h1234_5678, 1, ST_INSERT, 3, 3, 0);
		// equal priority, must leave after id 1
		add_row(0, 0, KIND_ENQ, 8'd128, 16'd2, 32'h9ABC_DEF0, 1, ST_INSERT, 4, 4, 0);
		add_row(0, 0, KIND_ENQ, 8'd0, 16'd3, 32'h0F0F_A5A5, 1, ST_INSERT, 5, 5, 0);
		repeat (5)
			add_row(0, 0, KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, KIND_DEQ, 0, 0, 0, 1, ST_EMPTY, 0, 5, 0);
		// zero capacity drops everything
		add_row(1, 5'd0, KIND_ENQ, 8'd7, 16'd4, 32'h5555_AAAA, 1, ST_DROP, 0, 6, 1);
		add_row(0, 0, KIND_ENQ, 8'd255, 16'd5, 32'hAAAA_5555, 1, ST_DROP, 0, 7, 2);
		// above depth acts as depth
		add_row(1, 5'd31, KIND_ENQ, 8'd9, 16'd6, 32'h0000_FFFF, 1, ST_INSERT, 1, 8, 2);
		add_row(1, 5'd1, KIND_ENQ, 8'd200, 16'd7, 32'hFFFF_0000, 1, ST_DROP, 1, 9, 3);
		add_row(0, 0, KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, KIND_ENQ, 8'd1, 16'd8, 32'h1357_9BDF, 1, ST_INSERT, 1, 10, 3);
		add_row(1, 5'd16, KIND_ENQ, 8'd50, 16'd9, 32'h2468_ACE0, 1, ST_INSERT, 2, 11, 3);
		add_row(0, 0, KIND_ENQ, 8'd60, 16'd10, 32'hDEAD_0001, 1, ST_INSERT, 3, 12, 3);
		// limit lowered below occupancy: entries stay, arrivals drop
		add_row(1, 5'd2, KIND_ENQ, 8'd70, 16'd11, 32'hC0FF_EE00, 1, ST_DROP, 3, 13, 4);
		add_row(0, 0, KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, KIND_ENQ, 8'd80, 16'd12, 32'h7777_8888, 1, ST_DROP, 2, 14, 5);
		add_row(0, 0, KIND_DEQ, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(0, 0, KIND_ENQ, 8'd90, 16'd13, 32'h3C3C_C3C3, 1, ST_INSERT, 2, 15, 5);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].cfg_on)
				write_capacity(plan[i].cfg_val);
			ent.prio    = plan[i].prio;
			ent.id      = plan[i].id;
			ent.size    = plan[i].fill;
			ent.src     = plan[i].fill[7:0];
			ent.dst     = plan[i].fill[15:8];
			ent.arrival = plan[i].fill;
			tres = '0;
			tres.status   = plan[i].st;
			tres.occ      = plan[i].occ;
			tres.attempts = plan[i].att;
			tres.drops    = plan[i].drp;
			drive_item(plan[i].knd, ent, plan[i].typed, tres);
		end

		for (int p = 0; p < PHASES; p++) begin
			write_capacity(cap_plan[p]);
			calm = (p == 4);
			if (p == 2)
				long_hold_req = 1'b1;
			enq_pct = (p % 3 == 0) ? 35 : ((p % 3 == 1) ? 55 : 75);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 6 && n == PHASE_ITEMS / 2)
					drain_results();
				sel = $urandom_range(99);
				if (sel < 50)
					ent.prio = 8'($urandom_range(3));
				else if (sel < 75)
					ent.prio = 8'($urandom);
				else
					ent.prio = (sel < 87) ? 8'h00 : 8'hFF;
				ent.id      = 16'($urandom);
				ent.size    = $urandom;
				ent.src     = 8'($urandom);
				ent.dst     = 8'($urandom);
				ent.arrival = $urandom;
				drive_item(($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ, ent, 1'b0, '0);
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (5) @(negedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("[bounded_stable_priority_queue_unit] OK");
		else
			$display("[bounded_stable_priority_queue_unit] ERROR");
		$finish;
	end

endmodule
